[rtl/core/rect_collision_watch_table_defines.svh]
// ----------------------------------------------------------------------------
// rect_collision_watch_table_defines
// Assertion macros for the collision watch table.
// ----------------------------------------------------------------------------
`ifndef RECT_COLLISION_WATCH_TABLE_DEFINES_SVH
`define RECT_COLLISION_WATCH_TABLE_DEFINES_SVH
`ifndef ASSERT_OFF
`define RCWT_ASSERT(label, clk_s, rst_s, prop, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define RCWT_ASSERT_NORST(label, clk_s, prop, msg) \
    label: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define RCWT_ASSERT(label, clk_s, rst_s, prop, msg)
`define RCWT_ASSERT_NORST(label, clk_s, prop, msg)
`endif
`endif

[rtl/core/rcwt_pkg.sv]
// ----------------------------------------------------------------------------
// rcwt_pkg
// Shared types and codes for the rectangle collision watch table.
// ----------------------------------------------------------------------------
package rcwt_pkg;

    localparam int MAX_SLOTS_DEF = 8;

    localparam logic [2:0] CMD_REGISTER   = 3'd0;
    localparam logic [2:0] CMD_UNREGISTER = 3'd1;
    localparam logic [2:0] CMD_WATCH_ON   = 3'd2;
    localparam logic [2:0] CMD_WATCH_OFF  = 3'd3;
    localparam logic [2:0] CMD_SET_BOX    = 3'd4;
    localparam logic [2:0] CMD_PROCESS    = 3'd5;

    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_EVENT = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_UNKNOWN     = 3'd1;
    localparam logic [2:0] ST_WATCHED     = 3'd2;
    localparam logic [2:0] ST_NOT_WATCHED = 3'd3;
    localparam logic [2:0] ST_FULL        = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_PAIR,
        S_DONE,
        S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;     // latch the input beat
        logic exec;        // run a table command
        logic shift;       // one step of watch list removal
        logic pair_init;   // start process walk
        logic pair_step;   // check one pair, advance
        logic load_ack;    // load ack result
        logic load_done;   // load done result
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic is_process;
        logic need_shift;  // watch off found an entry to remove
        logic shift_end;
        logic walk_end;    // last pair being checked, or list done
        logic hit;         // current pair overlaps
    } stat_t;

endpackage

[rtl/core/rcwt_ctrl.sv]
// ----------------------------------------------------------------------------
// rcwt_ctrl
// Command sequencer: decode, watch list shifting, pair walk, result handoff.
// ----------------------------------------------------------------------------
module rcwt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic           out_full,
    input  logic           out_take,
    input  rcwt_pkg::stat_t st,
    output rcwt_pkg::ctrl_t ctl,
    output logic           out_load
);
    import rcwt_pkg::*;

    state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_EXEC;
            S_EXEC:
            begin
                if (st.is_process)      state_next = S_PAIR;
                else if (st.need_shift) state_next = S_SHIFT;
                else                    state_next = S_OUT;
            end
            S_SHIFT: if (st.shift_end) state_next = S_OUT;
            S_PAIR:
            begin
                if (!(st.hit && out_full && !out_take) && st.walk_end)
                    state_next = S_DONE;
            end
            S_DONE:  if (!out_full || out_take) state_next = S_IDLE;
            S_OUT:   if (!out_full || out_take) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ctl = '0;
        out_load = 1'b0;
        in_stall = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:  ctl.capture = in_valid;
            S_EXEC:
            begin
                ctl.exec = 1'b1;
                ctl.pair_init = st.is_process;
            end
            S_SHIFT: ctl.shift = 1'b1;
            S_PAIR:
            begin
                if (!(st.hit && out_full && !out_take))
                begin
                    ctl.pair_step = 1'b1;
                    out_load = st.hit;
                end
            end
            S_DONE:
            begin
                ctl.load_done = !out_full || out_take;
                out_load = ctl.load_done;
            end
            S_OUT:
            begin
                ctl.load_ack = !out_full || out_take;
                out_load = ctl.load_ack;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else        state_reg <= state_next;
    end

endmodule

[rtl/core/rcwt_datapath.sv]
// ----------------------------------------------------------------------------
// rcwt_datapath
// Slot table, watch list, overlap unit and result register.
// ----------------------------------------------------------------------------
module rcwt_datapath #(
    parameter int MAX_SLOTS = rcwt_pkg::MAX_SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rcwt_pkg::ctrl_t    ctl,
    output rcwt_pkg::stat_t    st,
    input  logic               out_load,
    input  logic               out_take,
    output logic               out_full,
    input  logic [2:0]         command,
    input  logic [2:0]         handle,
    input  logic [1:0]         impact,
    input  logic signed [15:0] box_x,
    input  logic signed [15:0] box_y,
    input  logic [14:0]        box_w,
    input  logic [14:0]        box_h,
    output logic [1:0]         kind,
    output logic [2:0]         status,
    output logic [2:0]         handle_active,
    output logic [2:0]         handle_other,
    output logic signed [15:0] cut_x,
    output logic signed [15:0] cut_y,
    output logic [14:0]        cut_w,
    output logic [14:0]        cut_h,
    output logic [1:0]         impact_on_other,
    output logic [1:0]         impact_on_active,
    output logic               last
);
    import rcwt_pkg::*;

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);

    // captured beat
    logic [2:0]         cmd_reg;
    logic [2:0]         hnd_reg;
    logic [1:0]         imp_reg;
    logic signed [15:0] bx_reg, by_reg;
    logic [14:0]        bw_reg, bh_reg;

    logic [MAX_SLOTS-1:0]  occ_reg;
    logic [1:0]            simp_reg [MAX_SLOTS];
    logic signed [15:0]    sx_reg [MAX_SLOTS];
    logic signed [15:0]    sy_reg [MAX_SLOTS];
    logic [14:0]           sw_reg [MAX_SLOTS];
    logic [14:0]           sh_reg [MAX_SLOTS];
    logic [CW-1:0]         used_reg;
    logic [IW-1:0]         wl_reg [MAX_SLOTS];
    logic [CW-1:0]         wcnt_reg;
    logic [2:0]            ack_st_reg;
    logic [IW-1:0]         ack_h_reg;
    logic [IW-1:0]         sh_pos_reg;
    logic [CW-1:0]         wi_reg;  // walk list index
    logic [IW-1:0]         oj_reg;  // walk other slot

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg <= command; hnd_reg <= handle; imp_reg <= impact;
            bx_reg <= box_x; by_reg <= box_y; bw_reg <= box_w; bh_reg <= box_h;
        end
    end

    // handle checks
    logic          h_known;
    logic [IW-1:0] h_idx;
    logic          w_found;
    logic [IW-1:0] w_pos;
    logic          f_found;
    logic [IW-1:0] f_idx;
    assign h_known = (4'(used_reg) > {1'b0, hnd_reg})
                     && ({1'b0, hnd_reg} < 4'(MAX_SLOTS));
    assign h_idx = hnd_reg[IW-1:0];

    always_comb
    begin
        w_found = 1'b0;
        w_pos = '0;
        f_found = 1'b0;
        f_idx = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--)
        begin
            if (CW'(i) < wcnt_reg && 3'(wl_reg[i]) == hnd_reg)
            begin
                w_found = 1'b1;
                w_pos = IW'(i);
            end
            if (CW'(i) < used_reg && !occ_reg[i])
            begin
                f_found = 1'b1;
                f_idx = IW'(i);
            end
        end
    end

    // walk: current pair
    logic [IW-1:0] a_idx;
    logic          a_ok, j_ok, pair_ok, hit;
    logic signed [16:0] ax1, bx1, ay1, by1, x0, x1, y0, y1, dw, dh;
    assign a_idx = wl_reg[wi_reg[IW-1:0]];
    assign a_ok = occ_reg[a_idx];
    assign j_ok = occ_reg[oj_reg] && (oj_reg != a_idx) && (CW'(oj_reg) < used_reg);
    always_comb
    begin
        ax1 = 17'(sx_reg[a_idx]) + 17'($signed({1'b0, sw_reg[a_idx]}));
        bx1 = 17'(sx_reg[oj_reg]) + 17'($signed({1'b0, sw_reg[oj_reg]}));
        ay1 = 17'(sy_reg[a_idx]) + 17'($signed({1'b0, sh_reg[a_idx]}));
        by1 = 17'(sy_reg[oj_reg]) + 17'($signed({1'b0, sh_reg[oj_reg]}));
        x0 = (sx_reg[a_idx] > sx_reg[oj_reg]) ? 17'(sx_reg[a_idx]) : 17'(sx_reg[oj_reg]);
        y0 = (sy_reg[a_idx] > sy_reg[oj_reg]) ? 17'(sy_reg[a_idx]) : 17'(sy_reg[oj_reg]);
        x1 = (ax1 < bx1) ? ax1 : bx1;
        y1 = (ay1 < by1) ? ay1 : by1;
        dw = x1 - x0;
        dh = y1 - y0;
    end
    assign pair_ok = (wi_reg < wcnt_reg) && a_ok && j_ok;
    assign hit = pair_ok && (sw_reg[a_idx] != 0) && (sh_reg[a_idx] != 0)
                 && (sw_reg[oj_reg] != 0) && (sh_reg[oj_reg] != 0)
                 && (dw > 0) && (dh > 0);

    logic walk_end;
    assign walk_end = (wi_reg >= wcnt_reg) ||
                      ((wi_reg + CW'(1) >= wcnt_reg) && (oj_reg == IW'(MAX_SLOTS - 1)));

    assign st.is_process = (cmd_reg == CMD_PROCESS);
    assign st.need_shift = (cmd_reg == CMD_WATCH_OFF) && h_known && w_found;
    assign st.shift_end  = (CW'(sh_pos_reg) + CW'(1) >= wcnt_reg);
    assign st.walk_end   = walk_end;
    assign st.hit        = hit;

    // table state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
            used_reg <= '0;
            wcnt_reg <= '0;
        end
        else if (ctl.exec)
        begin
            case (cmd_reg)
                CMD_REGISTER:
                begin
                    if (f_found)
                        occ_reg[f_idx] <= 1'b1;
                    else if (used_reg < CW'(MAX_SLOTS))
                    begin
                        occ_reg[used_reg[IW-1:0]] <= 1'b1;
                        used_reg <= used_reg + CW'(1);
                    end
                end
                CMD_UNREGISTER: if (h_known) occ_reg[h_idx] <= 1'b0;
                CMD_WATCH_ON:
                    if (h_known && !w_found && wcnt_reg < CW'(MAX_SLOTS))
                        wcnt_reg <= wcnt_reg + CW'(1);
                default: ;
            endcase
        end
        else if (ctl.shift && st.shift_end)
            wcnt_reg <= wcnt_reg - CW'(1);
    end

    // slot payload, ack, list and walk registers
    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            ack_st_reg <= ST_OK;
            ack_h_reg <= '0;
            sh_pos_reg <= w_pos;
            case (cmd_reg)
                CMD_REGISTER:
                begin
                    if (f_found || used_reg < CW'(MAX_SLOTS))
                    begin
                        ack_h_reg <= f_found ? f_idx : used_reg[IW-1:0];
                        simp_reg[f_found ? f_idx : used_reg[IW-1:0]] <= imp_reg;
                        sx_reg[f_found ? f_idx : used_reg[IW-1:0]] <= bx_reg;
                        sy_reg[f_found ? f_idx : used_reg[IW-1:0]] <= by_reg;
                        sw_reg[f_found ? f_idx : used_reg[IW-1:0]] <= bw_reg;
                        sh_reg[f_found ? f_idx : used_reg[IW-1:0]] <= bh_reg;
                    end
                    else
                        ack_st_reg <= ST_FULL;
                end
                CMD_UNREGISTER: if (!h_known) ack_st_reg <= ST_UNKNOWN;
                CMD_WATCH_ON:
                begin
                    if (!h_known) ack_st_reg <= ST_UNKNOWN;
                    else if (w_found) ack_st_reg <= ST_WATCHED;
                    else if (wcnt_reg < CW'(MAX_SLOTS))
                        wl_reg[wcnt_reg[IW-1:0]] <= h_idx;
                end
                CMD_WATCH_OFF:
                begin
                    if (!h_known) ack_st_reg <= ST_UNKNOWN;
                    else if (!w_found) ack_st_reg <= ST_NOT_WATCHED;
                end
                CMD_SET_BOX:
                begin
                    if (!h_known || !occ_reg[h_idx]) ack_st_reg <= ST_UNKNOWN;
                    else
                    begin
                        sx_reg[h_idx] <= bx_reg; sy_reg[h_idx] <= by_reg;
                        sw_reg[h_idx] <= bw_reg; sh_reg[h_idx] <= bh_reg;
                    end
                end
                default: ;
            endcase
        end
        // one list move per cycle
        if (ctl.shift && !st.shift_end)
        begin
            wl_reg[sh_pos_reg] <= wl_reg[sh_pos_reg + IW'(1)];
            sh_pos_reg <= sh_pos_reg + IW'(1);
        end
        if (ctl.pair_init)
        begin
            wi_reg <= '0;
            oj_reg <= '0;
        end
        else if (ctl.pair_step)
        begin
            if (oj_reg == IW'(MAX_SLOTS - 1) || !a_ok)
            begin
                oj_reg <= '0;
                wi_reg <= wi_reg + CW'(1);
            end
            else
                oj_reg <= oj_reg + IW'(1);
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_full <= 1'b0;
        else if (out_load) out_full <= 1'b1;
        else if (out_take) out_full <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            kind <= KIND_ACK; status <= ST_OK;
            handle_active <= '0; handle_other <= '0;
            cut_x <= '0; cut_y <= '0; cut_w <= '0; cut_h <= '0;
            impact_on_other <= '0; impact_on_active <= '0;
            last <= 1'b1;
            if (ctl.pair_step)
            begin
                kind <= KIND_EVENT;
                handle_active <= 3'(a_idx);
                handle_other <= 3'(oj_reg);
                cut_x <= x0[15:0]; cut_y <= y0[15:0];
                cut_w <= dw[14:0]; cut_h <= dh[14:0];
                impact_on_other <= simp_reg[a_idx];
                impact_on_active <= simp_reg[oj_reg];
                last <= 1'b0;
            end
            else if (ctl.load_done)
                kind <= KIND_DONE;
            else
            begin
                status <= ack_st_reg;
                handle_active <= 3'(ack_h_reg);
            end
        end
    end

endmodule

[rtl/core/rect_collision_watch_table.sv]
// ----------------------------------------------------------------------------
// rect_collision_watch_table
// Object table with a watch list and rectangle overlap detection.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one command beat. Output
//   channel (out_valid/out_stall) carries result beats; the final beat of a
//   command has last set.
//   One command is handled at a time; in_stall is high while it runs.
//   Table commands: capture, execute, then the acknowledge.
//   Watch off adds a shift pass that moves each list entry behind the
//   removed one forward by one place.
//   Process visits MAX_SLOTS pair slots per watched entry, one per cycle
//   while no hit waits on a full output (a freed watched slot is passed
//   over at once), then the done beat.
//   The pair walk goes through the shared overlap unit.
//   A stalled receiver holds the output register; the walk pauses on a hit
//   until the pending beat is taken.
//   Reset empties the table and the watch list; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "rect_collision_watch_table_defines.svh"
module rect_collision_watch_table #(
    parameter int MAX_SLOTS = rcwt_pkg::MAX_SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         command,
    input  logic [2:0]         handle,
    input  logic [1:0]         impact,
    input  logic signed [15:0] box_x,
    input  logic signed [15:0] box_y,
    input  logic [14:0]        box_w,
    input  logic [14:0]        box_h,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic [2:0]         status,
    output logic [2:0]         handle_active,
    output logic [2:0]         handle_other,
    output logic signed [15:0] cut_x,
    output logic signed [15:0] cut_y,
    output logic [14:0]        cut_w,
    output logic [14:0]        cut_h,
    output logic [1:0]         impact_on_other,
    output logic [1:0]         impact_on_active,
    output logic               last
);
    import rcwt_pkg::*;

    ctrl_t ctl;
    stat_t st;
    logic  out_load, out_take;

    assign out_take = out_valid && !out_stall;

    rcwt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .out_full(out_valid), .out_take(out_take),
        .st(st), .ctl(ctl), .out_load(out_load)
    );

    rcwt_datapath #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .st(st),
        .out_load(out_load), .out_take(out_take), .out_full(out_valid),
        .command(command), .handle(handle), .impact(impact),
        .box_x(box_x), .box_y(box_y), .box_w(box_w), .box_h(box_h),
        .kind(kind), .status(status), .handle_active(handle_active),
        .handle_other(handle_other), .cut_x(cut_x), .cut_y(cut_y),
        .cut_w(cut_w), .cut_h(cut_h), .impact_on_other(impact_on_other),
        .impact_on_active(impact_on_active), .last(last)
    );

    // a new result never overwrites one still waiting
    `RCWT_ASSERT(a_no_overwrite, clk, rst_n, out_load |-> (!out_valid || !out_stall), "result overwritten")
    // no input accepted while a command is in flight
    `RCWT_ASSERT(a_one_cmd, clk, rst_n, (in_valid && !in_stall) |=> in_stall, "input taken while busy")
    // an event is never the last beat
    `RCWT_ASSERT(a_event_not_last, clk, rst_n, (out_valid && kind == KIND_EVENT) |-> !last, "event marked last")

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives command beats into the collision watch table, predicts result
// beats from an internal copy of the table and watch list (directed rows
// type in their acks), and compares the results field by field in order.
// ----------------------------------------------------------------------------
module testbench;
    import rcwt_pkg::*;

    localparam int NSLOT = 8;

    typedef struct packed {
        logic [1:0]         kind;
        logic [2:0]         status;
        logic [2:0]         handle_active;
        logic [2:0]         handle_other;
        logic signed [15:0] cut_x;
        logic signed [15:0] cut_y;
        logic [14:0]        cut_w;
        logic [14:0]        cut_h;
        logic [1:0]         impact_on_other;
        logic [1:0]         impact_on_active;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [2:0]         command;
        logic [2:0]         handle;
        logic [1:0]         impact;
        logic signed [15:0] box_x;
        logic signed [15:0] box_y;
        logic [14:0]        box_w;
        logic [14:0]        box_h;
    } beat_t;

    // directed row: beat plus optional typed-in ack
    typedef struct {
        beat_t      b;
        bit         has_ack;
        logic [2:0] st;
        logic [2:0] ha;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         command;
    logic [2:0]         handle;
    logic [1:0]         impact;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic [14:0]        box_w;
    logic [14:0]        box_h;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         kind;
    logic [2:0]         status;
    logic [2:0]         handle_active;
    logic [2:0]         handle_other;
    logic signed [15:0] cut_x;
    logic signed [15:0] cut_y;
    logic [14:0]        cut_w;
    logic [14:0]        cut_h;
    logic [1:0]         impact_on_other;
    logic [1:0]         impact_on_active;
    logic               last;

    rect_collision_watch_table DUT (.*);

    // predictor state
    bit          occ [NSLOT];
    logic [1:0]  imp [NSLOT];
    int          bx [NSLOT], by [NSLOT], bw [NSLOT], bh [NSLOT];
    int          used_cnt;
    int          watched [$];

    result_t     expected_results [$];
    int          errors;
    int          send_idle_pct, recv_idle_pct;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50000000;
        $display("FAIL rect_collision_watch_table");
        $finish;
    end

    function automatic result_t ack(logic [2:0] st, logic [2:0] ha);
        result_t r;
        r = '0;
        r.kind = KIND_ACK;
        r.status = st;
        r.handle_active = ha;
        r.last = 1'b1;
        return r;
    endfunction

    // append one beat to the expected queue
    function automatic void expect_beat(result_t r);
        expected_results = {expected_results, r};
    endfunction

    // apply one command to the table copy and queue its result beats
    function automatic void predict_table(beat_t b);
        int i, j, a, pos, x0, x1, y0, y1;
        result_t r;
        logic [2:0] st;
        logic [2:0] ha;
        st = ST_OK;
        ha = '0;
        case (b.command)
            CMD_REGISTER:
            begin
                for (i = 0; i < used_cnt; i++)
                    if (!occ[i]) break;
                if (i >= NSLOT)
                    st = ST_FULL;
                else
                begin
                    if (i >= used_cnt) used_cnt = i + 1;
                    occ[i] = 1;
                    imp[i] = b.impact;
                    bx[i] = b.box_x; by[i] = b.box_y;
                    bw[i] = b.box_w; bh[i] = b.box_h;
                    ha = 3'(i);
                end
            end
            CMD_UNREGISTER:
                if (b.handle >= used_cnt) st = ST_UNKNOWN;
                else occ[b.handle] = 0;
            CMD_WATCH_ON:
            begin
                pos = -1;
                foreach (watched[k]) if (watched[k] == b.handle) pos = k;
                if (b.handle >= used_cnt) st = ST_UNKNOWN;
                else if (pos >= 0) st = ST_WATCHED;
                else if (watched.size() < NSLOT) watched = {watched, int'(b.handle)};
            end
            CMD_WATCH_OFF:
            begin
                pos = -1;
                foreach (watched[k]) if (watched[k] == b.handle) pos = k;
                if (b.handle >= used_cnt) st = ST_UNKNOWN;
                else if (pos < 0) st = ST_NOT_WATCHED;
                else watched.delete(pos);
            end
            CMD_SET_BOX:
                if (b.handle >= used_cnt || !occ[b.handle]) st = ST_UNKNOWN;
                else
                begin
                    bx[b.handle] = b.box_x; by[b.handle] = b.box_y;
                    bw[b.handle] = b.box_w; bh[b.handle] = b.box_h;
                end
            CMD_PROCESS:
            begin
                foreach (watched[k])
                begin
                    a = watched[k];
                    if (!occ[a]) continue;
                    for (j = 0; j < used_cnt; j++)
                    begin
                        if (j == a || !occ[j]) continue;
                        if (bw[a] <= 0 || bh[a] <= 0 || bw[j] <= 0 || bh[j] <= 0)
                            continue;
                        x0 = bx[a] > bx[j] ? bx[a] : bx[j];
                        x1 = (bx[a] + bw[a]) < (bx[j] + bw[j]) ? bx[a] + bw[a]
                                                               : bx[j] + bw[j];
                        y0 = by[a] > by[j] ? by[a] : by[j];
                        y1 = (by[a] + bh[a]) < (by[j] + bh[j]) ? by[a] + bh[a]
                                                               : by[j] + bh[j];
                        if (x1 <= x0 || y1 <= y0) continue;
                        r = '0;
                        r.kind = KIND_EVENT;
                        r.handle_active = 3'(a);
                        r.handle_other = 3'(j);
                        r.cut_x = 16'(x0); r.cut_y = 16'(y0);
                        r.cut_w = 15'(x1 - x0); r.cut_h = 15'(y1 - y0);
                        r.impact_on_other = imp[a];
                        r.impact_on_active = imp[j];
                        expect_beat(r);
                    end
                end
                r = '0;
                r.kind = KIND_DONE;
                r.last = 1'b1;
                expect_beat(r);
                return;
            end
            default: ;
        endcase
        expect_beat(ack(st, ha));
    endfunction

    // valid stays high after an accept until the next beat or an idle cycle
    task automatic send_beat(beat_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        {command, handle, impact, box_x, box_y, box_w, box_h} <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // receiver: random stall, compare on accepted beats
    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        result_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {kind, status, handle_active, handle_other, cut_x, cut_y,
                   cut_w, cut_h, impact_on_other, impact_on_active, last};
            if (expected_results.size() == 0)
            begin
                $error("unexpected result beat kind=%0d", kind);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.kind !== want.kind)
                begin $error("kind exp %0d got %0d", want.kind, got.kind); errors++; end
                if (got.status !== want.status)
                begin $error("status exp %0d got %0d", want.status, got.status); errors++; end
                if (got.handle_active !== want.handle_active)
                begin
                    $error("handle_active exp %0d got %0d", want.handle_active,
                           got.handle_active);
                    errors++;
                end
                if (got.handle_other !== want.handle_other)
                begin
                    $error("handle_other exp %0d got %0d", want.handle_other,
                           got.handle_other);
                    errors++;
                end
                if (got.cut_x !== want.cut_x)
                begin $error("cut_x exp %0d got %0d", want.cut_x, got.cut_x); errors++; end
                if (got.cut_y !== want.cut_y)
                begin $error("cut_y exp %0d got %0d", want.cut_y, got.cut_y); errors++; end
                if (got.cut_w !== want.cut_w)
                begin $error("cut_w exp %0d got %0d", want.cut_w, got.cut_w); errors++; end
                if (got.cut_h !== want.cut_h)
                begin $error("cut_h exp %0d got %0d", want.cut_h, got.cut_h); errors++; end
                if (got.impact_on_other !== want.impact_on_other)
                begin
                    $error("impact_on_other exp %0d got %0d", want.impact_on_other,
                           got.impact_on_other);
                    errors++;
                end
                if (got.impact_on_active !== want.impact_on_active)
                begin
                    $error("impact_on_active exp %0d got %0d", want.impact_on_active,
                           got.impact_on_active);
                    errors++;
                end
                if (got.last !== want.last)
                begin $error("last exp %0d got %0d", want.last, got.last); errors++; end
            end
        end
    end

    function automatic beat_t mk(logic [2:0] c, logic [2:0] h, logic [1:0] im,
                                 int x, int y, int w, int hh);
        beat_t b;
        b.command = c; b.handle = h; b.impact = im;
        b.box_x = 16'(x); b.box_y = 16'(y); b.box_w = 15'(w); b.box_h = 15'(hh);
        return b;
    endfunction

    // random beat, mostly small clustered boxes so overlaps happen
    function automatic beat_t rand_beat();
        beat_t b;
        int r;
        b = '0;
        r = $urandom_range(99);
        if (r < 25) b.command = CMD_REGISTER;
        else if (r < 37) b.command = CMD_UNREGISTER;
        else if (r < 55) b.command = CMD_WATCH_ON;
        else if (r < 63) b.command = CMD_WATCH_OFF;
        else if (r < 78) b.command = CMD_SET_BOX;
        else if (r < 97) b.command = CMD_PROCESS;
        else b.command = 3'($urandom_range(7, 6));
        b.handle = 3'($urandom_range(7));
        b.impact = 2'($urandom_range(3));
        if ($urandom_range(9) < 8)
        begin
            b.box_x = 16'($urandom_range(60) - 30);
            b.box_y = 16'($urandom_range(60) - 30);
            b.box_w = 15'($urandom_range(40));
            b.box_h = 15'($urandom_range(40));
        end
        else
        begin
            b.box_x = 16'($urandom);
            b.box_y = 16'($urandom);
            b.box_w = 15'($urandom);
            b.box_h = 15'($urandom);
        end
        return b;
    endfunction

    task automatic wait_drained();
        int n;
        n = 0;
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        while (n < 80)
        begin
            @(negedge clk);
            n++;
        end
    endtask

    initial
    begin
        row_t rows [$];
        row_t rw;
        beat_t b;
        int i, phase;

        errors = 0;
        used_cnt = 0;
        in_valid = 0;
        out_stall = 0;
        {command, handle, impact, box_x, box_y, box_w, box_h} = '0;
        send_idle_pct = 38;
        recv_idle_pct = 70;
        rst_n = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed table: boundary handles, full table, freed watch, extremes
        rw.has_ack = 1;
        rw.b = mk(CMD_UNREGISTER, 0, 0, 0, 0, 0, 0);
        rw.st = ST_UNKNOWN; rw.ha = 0; rows = {rows, rw};
        rw.b = mk(CMD_PROCESS, 0, 0, 0, 0, 0, 0); rw.has_ack = 0; rows = {rows, rw};
        rw.has_ack = 1;
        rw.b = mk(CMD_REGISTER, 0, 3, -32768, -32768, 32767, 32767);
        rw.st = ST_OK; rw.ha = 0; rows = {rows, rw};
        rw.b = mk(CMD_REGISTER, 7, 1, 32767, 32767, 32767, 32767);
        rw.ha = 1; rows = {rows, rw};
        rw.b = mk(CMD_REGISTER, 0, 2, -100, -100, 200, 200); rw.ha = 2; rows = {rows, rw};
        rw.b = mk(CMD_REGISTER, 0, 0, 0, 0, 0, 10); rw.ha = 3; rows = {rows, rw};
        rw.b = mk(CMD_REGISTER, 0, 1, 100, 0, 10, 10); rw.ha = 4; rows = {rows, rw};
        rw.b = mk(CMD_REGISTER, 0, 2, 0, 0, 10, 10); rw.ha = 5; rows = {rows, rw};
        rw.b = mk(CMD_REGISTER, 0, 3, 10, 0, 10, 10); rw.ha = 6; rows = {rows, rw};
        rw.b = mk(CMD_REGISTER, 0, 0, 5, 5, 10, 10); rw.ha = 7; rows = {rows, rw};
        rw.b = mk(CMD_REGISTER, 0, 0, 0, 0, 1, 1); rw.st = ST_FULL; rw.ha = 0;
        rows = {rows, rw};
        rw.st = ST_OK; rw.ha = 0;
        rw.b = mk(CMD_WATCH_ON, 5, 0, 0, 0, 0, 0); rows = {rows, rw};
        rw.b = mk(CMD_WATCH_ON, 5, 0, 0, 0, 0, 0); rw.st = ST_WATCHED; rows = {rows, rw};
        rw.b = mk(CMD_WATCH_OFF, 0, 0, 0, 0, 0, 0); rw.st = ST_NOT_WATCHED;
        rows = {rows, rw};
        rw.st = ST_OK;
        rw.b = mk(CMD_WATCH_ON, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
        rw.b = mk(CMD_WATCH_ON, 2, 0, 0, 0, 0, 0); rows = {rows, rw};
        rw.b = mk(CMD_PROCESS, 0, 0, 0, 0, 0, 0); rw.has_ack = 0; rows = {rows, rw};
        rw.has_ack = 1;
        rw.b = mk(CMD_UNREGISTER, 2, 0, 0, 0, 0, 0); rows = {rows, rw};
        rw.b = mk(CMD_UNREGISTER, 2, 0, 0, 0, 0, 0); rows = {rows, rw};
        rw.b = mk(CMD_SET_BOX, 2, 0, 0, 0, 5, 5); rw.st = ST_UNKNOWN; rows = {rows, rw};
        rw.st = ST_OK;
        rw.b = mk(CMD_SET_BOX, 1, 0, 2, 2, 4, 4); rows = {rows, rw};
        rw.b = mk(CMD_PROCESS, 0, 0, 0, 0, 0, 0); rw.has_ack = 0; rows = {rows, rw};
        rw.has_ack = 1;
        rw.b = mk(CMD_WATCH_OFF, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
        rw.b = mk(3'd6, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
        rw.b = mk(3'd7, 7, 3, -1, -1, 32767, 32767); rows = {rows, rw};

        foreach (rows[k])
        begin
            if (rows[k].has_ack)
            begin
                expect_beat(ack(rows[k].st, rows[k].ha));
                predict_table(rows[k].b);
                void'(expected_results.pop_back());
            end
            else
                predict_table(rows[k].b);
            send_beat(rows[k].b);
        end

        // pause the sender until every result has come
        wait_drained();

        // random part in three idling phases
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 70 : 0;
            recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 38 : 0;
            for (i = 0; i < 102; i++)
            begin
                b = rand_beat();
                predict_table(b);
                send_beat(b);
            end
        end

        wait_drained();
        if (errors == 0)
            $display("PASS rect_collision_watch_table");
        else
            $display("FAIL rect_collision_watch_table");
        $finish;
    end
endmodule
